// File: rtl/core/assert_macros.svh
// Assertion helpers used by the top-level RTL file.
// Each macro expects clock aclk and active-low reset aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WMD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WMD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/wmd_pkg.sv
package wmd_pkg;

    localparam int SAMPLE_BITS            = 16;
    localparam int MAX_COLUMNS            = 4096;
    localparam int MAX_COLUMNS_PER_SAMPLE = 64;

    localparam int N_W   = 21;
    localparam int W_W   = 13;
    localparam int H_W   = 10;
    localparam int COL_W = 13;
    localparam int BND_W = 22;
    localparam int REM_W = 14;
    localparam int CFG_W = 21;

    localparam logic [N_W-1:0] SAMPLE_COUNT_RST = N_W'(1024);
    localparam logic [W_W-1:0] TOTAL_WIDTH_RST  = W_W'(512);
    localparam logic [W_W-1:0] PLOT_WIDTH_RST   = W_W'(510);
    localparam logic [H_W-1:0] PLOT_HEIGHT_RST  = H_W'(256);

    typedef enum logic [1:0] {
        REG_SAMPLE_COUNT = 2'd0,
        REG_TOTAL_WIDTH  = 2'd1,
        REG_PLOT_WIDTH   = 2'd2,
        REG_PLOT_HEIGHT  = 2'd3
    } wmd_reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COUNT,
        ST_EMIT
    } wmd_state_t;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               start_of_buffer;
    } wmd_in_t;

    typedef struct packed {
        logic [11:0] column;
        logic [13:0] top_row;
        logic [14:0] bottom_row;
        logic        last;
        logic        dropped;
    } wmd_out_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] smp;
        logic                          sob;
    } wmd_item_t;

    typedef struct packed {
        logic [11:0]                   col;
        logic signed [SAMPLE_BITS-1:0] maxv;
        logic signed [SAMPLE_BITS-1:0] minv;
        logic                          last;
        logic                          dropped;
    } wmd_col_t;

    typedef struct packed {
        logic [N_W-1:0]   n;
        logic [W_W-1:0]   w;
        logic [COL_W-1:0] limit;
    } wmd_geom_t;

    typedef struct packed {
        logic [N_W-1:0]   q;
        logic [REM_W-1:0] r0;
        logic [REM_W-1:0] den;
        logic [BND_W-1:0] u0;
        logic [REM_W-1:0] rem0;
    } wmd_cst_t;

    typedef struct packed {
        logic [BND_W-1:0] nb;
        logic [REM_W-1:0] rem;
    } wmd_bnd_t;

    function automatic wmd_bnd_t advance(input wmd_bnd_t b, input wmd_cst_t c);
        logic [REM_W:0] sum;
        wmd_bnd_t       res;
        sum = {1'b0, b.rem} + {1'b0, c.r0};
        if (sum >= {1'b0, c.den}) begin
            res.nb  = b.nb + BND_W'(c.q) + BND_W'(1);
            res.rem = REM_W'(sum - {1'b0, c.den});
        end else begin
            res.nb  = b.nb + BND_W'(c.q);
            res.rem = sum[REM_W-1:0];
        end
        return res;
    endfunction

    function automatic logic [13:0] map_row(input logic [H_W-1:0] h,
                                            input logic signed [SAMPLE_BITS-1:0] v);
        logic [SAMPLE_BITS:0]      d;
        logic [SAMPLE_BITS+H_W:0]  x;
        d = (SAMPLE_BITS+1)'(1 << (SAMPLE_BITS - 1)) - {v[SAMPLE_BITS-1], v};
        x = (SAMPLE_BITS+H_W+1)'(h) * (SAMPLE_BITS+H_W+1)'(d)
            + (SAMPLE_BITS+H_W+1)'(1 << (SAMPLE_BITS - 5));
        return x[SAMPLE_BITS+9:SAMPLE_BITS-4];
    endfunction

endpackage

// File: rtl/core/wmd_div.sv
module wmd_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [wmd_pkg::N_W-1:0]   n,
    input  logic [wmd_pkg::W_W-1:0]   w,
    output logic                      busy,
    output logic                      done,
    output wmd_pkg::wmd_cst_t         cst
);

    localparam int N_W   = wmd_pkg::N_W;
    localparam int W_W   = wmd_pkg::W_W;
    localparam int REM_W = wmd_pkg::REM_W;
    localparam int BND_W = wmd_pkg::BND_W;
    localparam int CNT_W = $clog2(N_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [N_W-1:0]   dvd_reg, dvd_next;
    logic [W_W-1:0]   rem_reg, rem_next;
    logic [W_W-1:0]   w_reg, w_next;

    logic [W_W:0]     trial;
    logic [REM_W-1:0] two_r;
    logic             ge;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        w_next    = w_reg;
        trial     = {rem_reg, dvd_reg[N_W-1]};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = n;
            rem_next  = '0;
            w_next    = w;
        end else if (busy_reg) begin
            if (trial >= {1'b0, w_reg}) begin
                rem_next = W_W'(trial - {1'b0, w_reg});
                dvd_next = {dvd_reg[N_W-2:0], 1'b1};
            end else begin
                rem_next = trial[W_W-1:0];
                dvd_next = {dvd_reg[N_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(N_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        w_reg   <= w_next;
    end

    // Chunk constants: 2N = q*2W + r0, and (2N + W) = u0*2W + rem0.
    assign two_r    = {rem_reg, 1'b0};
    assign ge       = two_r >= REM_W'(w_reg);
    assign cst.q    = dvd_reg;
    assign cst.r0   = two_r;
    assign cst.den  = {w_reg, 1'b0};
    assign cst.u0   = BND_W'(dvd_reg) + BND_W'(ge);
    assign cst.rem0 = ge ? REM_W'(two_r - REM_W'(w_reg)) : REM_W'(two_r + REM_W'(w_reg));

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

// File: rtl/core/wmd_front.sv
module wmd_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                hold,
    input  logic                s_valid,
    output logic                s_ready,
    input  wmd_pkg::wmd_in_t    s_data,
    output logic                q_valid,
    input  logic                q_ready,
    output wmd_pkg::wmd_item_t  q_item
);

    localparam int SB = wmd_pkg::SAMPLE_BITS;

    wmd_pkg::wmd_item_t mem_reg [2];
    logic               wr_ptr_reg, wr_ptr_next;
    logic               rd_ptr_reg, rd_ptr_next;
    logic [1:0]         cnt_reg, cnt_next;

    logic               push, pop;
    wmd_pkg::wmd_item_t item_in;

    assign s_ready = (cnt_reg != 2'd2) && !hold;
    assign q_valid = cnt_reg != 2'd0;
    assign q_item  = mem_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    assign item_in.smp = s_data.sample[SB-1:0];
    assign item_in.sob = s_data.start_of_buffer;

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
        if (push) begin
            mem_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

// File: rtl/core/wmd_back.sv
module wmd_back #(
    parameter int MAX_PER = wmd_pkg::MAX_COLUMNS_PER_SAMPLE
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  wmd_pkg::wmd_geom_t  geom,
    input  wmd_pkg::wmd_cst_t   cst,
    input  logic                cst_load,
    input  logic                in_valid,
    output logic                in_ready,
    input  wmd_pkg::wmd_item_t  in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output wmd_pkg::wmd_col_t   out_col
);

    localparam int SB    = wmd_pkg::SAMPLE_BITS;
    localparam int N_W   = wmd_pkg::N_W;
    localparam int COL_W = wmd_pkg::COL_W;
    localparam int BND_W = wmd_pkg::BND_W;
    localparam int CNT_W = $clog2(MAX_PER + 1);

    wmd_pkg::wmd_state_t  state_reg, state_next;
    logic [N_W-1:0]       idx_reg, idx_next;
    logic [N_W-1:0]       k1_reg, k1_next;
    logic [COL_W-1:0]     col_reg, col_next;
    wmd_pkg::wmd_bnd_t    bnd_reg, bnd_next;
    logic                 open_reg, open_next;
    logic signed [SB-1:0] min_reg, min_next;
    logic signed [SB-1:0] max_reg, max_next;
    logic signed [SB-1:0] s_reg, s_next;
    logic [COL_W-1:0]     sh_col_reg, sh_col_next;
    wmd_pkg::wmd_bnd_t    sh_bnd_reg, sh_bnd_next;
    logic                 sh_open_reg, sh_open_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [CNT_W-1:0]     em_reg, em_next;
    logic                 drop_reg, drop_next;

    logic [N_W-1:0]       eff_idx;
    logic [COL_W-1:0]     eff_col;
    wmd_pkg::wmd_bnd_t    eff_bnd;
    logic                 eff_open;
    logic                 ignore;
    logic signed [SB-1:0] smp;
    logic                 cond_main, cond_sh;

    assign smp       = in_item.smp;
    assign cond_main = open_reg && (col_reg < geom.limit)
                       && (bnd_reg.nb <= BND_W'(k1_reg));
    assign cond_sh   = sh_open_reg && (sh_col_reg < geom.limit)
                       && (sh_bnd_reg.nb <= BND_W'(k1_reg));

    assign eff_idx  = in_item.sob ? '0 : idx_reg;
    assign eff_col  = in_item.sob ? '0 : col_reg;
    assign eff_open = in_item.sob ? 1'b0 : open_reg;
    assign eff_bnd  = in_item.sob ? wmd_pkg::wmd_bnd_t'({cst.u0, cst.rem0}) : bnd_reg;
    assign ignore   = (geom.n == '0) || (geom.w == '0) || (eff_idx >= geom.n);

    assign in_ready = state_reg == wmd_pkg::ST_IDLE;

    assign out_col.col     = col_reg[11:0];
    assign out_col.maxv    = max_reg;
    assign out_col.minv    = min_reg;
    assign out_col.last    = CNT_W'(em_reg + CNT_W'(1)) == cnt_reg;
    assign out_col.dropped = drop_reg;

    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        k1_next      = k1_reg;
        col_next     = col_reg;
        bnd_next     = bnd_reg;
        open_next    = open_reg;
        min_next     = min_reg;
        max_next     = max_reg;
        s_next       = s_reg;
        sh_col_next  = sh_col_reg;
        sh_bnd_next  = sh_bnd_reg;
        sh_open_next = sh_open_reg;
        cnt_next     = cnt_reg;
        em_next      = em_reg;
        drop_next    = drop_reg;
        out_valid    = 1'b0;

        unique case (state_reg)
            wmd_pkg::ST_IDLE: begin
                if (in_valid) begin
                    idx_next  = eff_idx;
                    col_next  = eff_col;
                    bnd_next  = eff_bnd;
                    open_next = eff_open;
                    if (!ignore) begin
                        if (!eff_open) begin
                            min_next = smp;
                            max_next = smp;
                        end else begin
                            min_next = (smp < min_reg) ? smp : min_reg;
                            max_next = (smp > max_reg) ? smp : max_reg;
                        end
                        open_next    = 1'b1;
                        s_next       = smp;
                        k1_next      = eff_idx + N_W'(1);
                        idx_next     = eff_idx + N_W'(1);
                        sh_col_next  = eff_col;
                        sh_bnd_next  = eff_bnd;
                        sh_open_next = 1'b1;
                        cnt_next     = '0;
                        drop_next    = 1'b0;
                        state_next   = wmd_pkg::ST_COUNT;
                    end
                end
            end
            wmd_pkg::ST_COUNT: begin
                em_next = '0;
                if (cond_sh) begin
                    if (cnt_reg == CNT_W'(MAX_PER)) begin
                        drop_next  = 1'b1;
                        state_next = wmd_pkg::ST_EMIT;
                    end else begin
                        cnt_next     = cnt_reg + CNT_W'(1);
                        sh_col_next  = sh_col_reg + COL_W'(1);
                        sh_bnd_next  = wmd_pkg::advance(sh_bnd_reg, cst);
                        sh_open_next = sh_bnd_reg.nb != BND_W'(k1_reg);
                    end
                end else begin
                    state_next = (cnt_reg == '0) ? wmd_pkg::ST_IDLE : wmd_pkg::ST_EMIT;
                end
            end
            wmd_pkg::ST_EMIT: begin
                if (!cond_main) begin
                    state_next = wmd_pkg::ST_IDLE;
                end else if (em_reg < cnt_reg) begin
                    out_valid = 1'b1;
                    if (out_ready) begin
                        em_next = em_reg + CNT_W'(1);
                    end
                end
                if (cond_main && (em_reg == cnt_reg || out_ready)) begin
                    col_next = col_reg + COL_W'(1);
                    bnd_next = wmd_pkg::advance(bnd_reg, cst);
                    if (bnd_reg.nb == BND_W'(k1_reg)) begin
                        open_next = 1'b0;
                    end else begin
                        min_next = s_reg;
                        max_next = s_reg;
                    end
                end
            end
            default: begin
                state_next = wmd_pkg::ST_IDLE;
            end
        endcase

        if (cst_load) begin
            idx_next  = '0;
            col_next  = '0;
            open_next = 1'b0;
            bnd_next  = {cst.u0, cst.rem0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= wmd_pkg::ST_IDLE;
            idx_reg   <= '0;
            col_reg   <= '0;
            open_reg  <= 1'b0;
            cnt_reg   <= '0;
            em_reg    <= '0;
            drop_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            col_reg   <= col_next;
            open_reg  <= open_next;
            cnt_reg   <= cnt_next;
            em_reg    <= em_next;
            drop_reg  <= drop_next;
        end
        k1_reg      <= k1_next;
        bnd_reg     <= bnd_next;
        min_reg     <= min_next;
        max_reg     <= max_next;
        s_reg       <= s_next;
        sh_col_reg  <= sh_col_next;
        sh_bnd_reg  <= sh_bnd_next;
        sh_open_reg <= sh_open_next;
    end

endmodule

// File: rtl/core/wmd_out.sv
module wmd_out (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic [wmd_pkg::H_W-1:0]  plot_height,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  wmd_pkg::wmd_col_t        in_col,
    output logic                     m_valid,
    input  logic                     m_ready,
    output wmd_pkg::wmd_out_t        m_data
);

    logic              val_reg, val_next;
    wmd_pkg::wmd_out_t data_reg, data_next;

    assign in_ready = !val_reg || m_ready;
    assign m_valid  = val_reg;
    assign m_data   = data_reg;

    always_comb begin
        val_next  = val_reg;
        data_next = data_reg;
        if (in_valid && in_ready) begin
            val_next             = 1'b1;
            data_next.column     = in_col.col;
            data_next.top_row    = wmd_pkg::map_row(plot_height, in_col.maxv);
            data_next.bottom_row = 15'(wmd_pkg::map_row(plot_height, in_col.minv)) + 15'd16;
            data_next.last       = in_col.last;
            data_next.dropped    = in_col.dropped;
        end else if (m_ready) begin
            val_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            val_reg <= 1'b0;
        end else begin
            val_reg <= val_next;
        end
        data_reg <= data_next;
    end

endmodule

// File: rtl/core/waveform_minmax_decimator_unit.sv
// Channel  Dir  Handshake           Payload
// s_       in   s_valid / s_ready   wmd_pkg::wmd_in_t, one sample per beat
// m_       out  m_valid / m_ready   wmd_pkg::wmd_out_t, one column bar per beat
// cfg_     in   cfg_we              cfg_idx, cfg_data, no read-back
//
// An ignored sample is handled in the back sequencer's idle state alone; one that closes
// no column passes idle and count, and one that closes columns also passes emit, since
// the sequencer walks the boundaries once to count them and once to emit.
// A two-beat input queue absorbs beats while the sequencer works.
// After reset and after every register write s_ready stays low while the boundary
// divider runs. A stall on m_ready holds the sequencer.
`include "assert_macros.svh"

module waveform_minmax_decimator_unit #(
    parameter int MAX_COLUMNS_PER_SAMPLE = wmd_pkg::MAX_COLUMNS_PER_SAMPLE
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_idx,
    input  logic [wmd_pkg::CFG_W-1:0]   cfg_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  wmd_pkg::wmd_in_t            s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output wmd_pkg::wmd_out_t           m_data
);

    localparam int N_W   = wmd_pkg::N_W;
    localparam int W_W   = wmd_pkg::W_W;
    localparam int H_W   = wmd_pkg::H_W;
    localparam int COL_W = wmd_pkg::COL_W;

    logic [N_W-1:0] n_reg, n_next;
    logic [W_W-1:0] w_reg, w_next;
    logic [W_W-1:0] pw_reg, pw_next;
    logic [H_W-1:0] h_reg, h_next;
    logic           pend_reg, pend_next;

    logic               div_busy, div_done, busy;
    wmd_pkg::wmd_cst_t  cst;
    wmd_pkg::wmd_geom_t geom;
    logic [W_W-1:0]     lim_a;

    logic               q_valid, q_ready;
    wmd_pkg::wmd_item_t q_item;
    logic               col_valid, col_ready;
    wmd_pkg::wmd_col_t  col_beat;
    logic [15:0]        top_ext;

    always_comb begin
        n_next    = n_reg;
        w_next    = w_reg;
        pw_next   = pw_reg;
        h_next    = h_reg;
        pend_next = 1'b0;
        if (cfg_we) begin
            pend_next = 1'b1;
            unique case (wmd_pkg::wmd_reg_idx_t'(cfg_idx))
                wmd_pkg::REG_SAMPLE_COUNT: n_next  = cfg_data[N_W-1:0];
                wmd_pkg::REG_TOTAL_WIDTH:  w_next  = cfg_data[W_W-1:0];
                wmd_pkg::REG_PLOT_WIDTH:   pw_next = cfg_data[W_W-1:0];
                wmd_pkg::REG_PLOT_HEIGHT:  h_next  = cfg_data[H_W-1:0];
                default:                   pend_next = 1'b1;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg    <= wmd_pkg::SAMPLE_COUNT_RST;
            w_reg    <= wmd_pkg::TOTAL_WIDTH_RST;
            pw_reg   <= wmd_pkg::PLOT_WIDTH_RST;
            h_reg    <= wmd_pkg::PLOT_HEIGHT_RST;
            pend_reg <= 1'b1;
        end else begin
            n_reg    <= n_next;
            w_reg    <= w_next;
            pw_reg   <= pw_next;
            h_reg    <= h_next;
            pend_reg <= pend_next;
        end
    end

    assign lim_a = (pw_reg < w_reg) ? pw_reg : w_reg;
    assign geom.n     = n_reg;
    assign geom.w     = w_reg;
    assign geom.limit = (32'(lim_a) > wmd_pkg::MAX_COLUMNS) ? COL_W'(wmd_pkg::MAX_COLUMNS)
                                                            : COL_W'(lim_a);

    assign busy = pend_reg || div_busy || div_done;

    wmd_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (pend_reg),
        .n       (n_reg),
        .w       (w_reg),
        .busy    (div_busy),
        .done    (div_done),
        .cst     (cst)
    );

    wmd_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .hold    (busy),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item)
    );

    wmd_back #(
        .MAX_PER (MAX_COLUMNS_PER_SAMPLE)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .geom      (geom),
        .cst       (cst),
        .cst_load  (div_done),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_item   (q_item),
        .out_valid (col_valid),
        .out_ready (col_ready),
        .out_col   (col_beat)
    );

    wmd_out u_out (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .plot_height (h_reg),
        .in_valid    (col_valid),
        .in_ready    (col_ready),
        .in_col      (col_beat),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    assign top_ext = 16'(m_data.top_row) + 16'd16;

    `WMD_ASSERT_NEXT(a_cfg_blocks_input, cfg_we, !s_ready, "input accepted right after a register write")
    `WMD_ASSERT_SAME(a_busy_blocks_input, busy, !s_ready, "input accepted while boundaries are computed")
    `WMD_ASSERT_SAME(a_emit_not_busy, col_valid, !div_busy && !pend_reg, "column beat while divider runs")
    `WMD_ASSERT_SAME(a_rows_ordered, m_valid, top_ext <= 16'(m_data.bottom_row), "bottom row above top row")

endmodule
